@@ hdl/fixed_block_free_list_allocator_assert.svh @@
// assertion macros for the free list allocator
`ifndef FIXED_BLOCK_FREE_LIST_ALLOCATOR_ASSERT_SVH
`define FIXED_BLOCK_FREE_LIST_ALLOCATOR_ASSERT_SVH

`ifndef SYNTHESIS
`define FBFLA_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("fbfla assertion failed");
`define FBFLA_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("fbfla forbidden condition");
`else
`define FBFLA_ASSERT(lbl, prop)
`define FBFLA_NEVER(lbl, expr)
`endif

`endif

@@ hdl/fbfla_pkg.sv @@
// types and constants of the free list allocator
package fbfla_pkg;

  localparam int CFG_IDX_W = 2;
  localparam int COUNT_W   = 11;
  localparam int ESIZE_W   = 13;
  localparam int SLOT_W    = 11;
  localparam int SPAN_W    = ESIZE_W + SLOT_W;
  localparam int OUT_ADDR_W = 32;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  localparam logic [31:0]        RST_BASE  = 32'd0;
  localparam logic [ESIZE_W-1:0] RST_ESIZE = 13'd16;
  localparam logic [SLOT_W-1:0]  RST_SLOTS = 11'd1024;

  typedef enum logic [1:0] {
    OP_INIT  = 2'd0,
    OP_ALLOC = 2'd1,
    OP_FREE  = 2'd2,
    OP_NOP   = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    STS_OK    = 3'd0,
    STS_EMPTY = 3'd1,
    STS_NULL  = 3'd2,
    STS_RANGE = 3'd3,
    STS_FULL  = 3'd4
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BASE  = 2'd0,
    CFG_ESIZE = 2'd1,
    CFG_SLOTS = 2'd2,
    CFG_NONE  = 2'd3
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_INIT,
    ST_ALLOC
  } state_t;

endpackage

@@ hdl/fbfla_stack_mem.sv @@
// free address stack memory, one write and one registered read port
module fbfla_stack_mem #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ hdl/fixed_block_free_list_allocator.sv @@
// fixed block pool allocator with a free address stack in memory
// results: free and no-op results are registered from the beat; alloc adds the stack read
//   register before the output register; init writes one stack entry per effective slot
// throughput: free 1 beat per cycle unless the output stalls; alloc and init block new beats
// reset: config and control registers take their default values, the stack is empty and not cleared
`include "fixed_block_free_list_allocator_assert.svh"
module fixed_block_free_list_allocator #(
  parameter int MAX_SLOTS = 1024,
  parameter int ADDR_BITS = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [1:0]                      in_opcode,
  input  logic [31:0]                     in_block_address,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [31:0]                     out_granted_address,
  output logic [2:0]                      out_status,
  output logic [fbfla_pkg::COUNT_W-1:0]   out_in_use_count,
  output logic [fbfla_pkg::COUNT_W-1:0]   out_high_water,
  output logic                            out_all_free,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [fbfla_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                     cfg_data
);
  import fbfla_pkg::*;

  localparam int MEM_AW = $clog2(MAX_SLOTS);
  localparam int TOP_W  = $clog2(MAX_SLOTS + 1);
  localparam int CMP_W  = (TOP_W > SLOT_W) ? TOP_W : SLOT_W;
  localparam int RW     = (ADDR_BITS > SPAN_W) ? ADDR_BITS : SPAN_W;

  state_t state_r, state_nxt;

  logic [31:0]          base_r;
  logic [ESIZE_W-1:0]   esize_r;
  logic [SLOT_W-1:0]    slots_r;

  logic [TOP_W-1:0]     stack_top_r, stack_top_nxt;
  logic [COUNT_W-1:0]   used_r, used_nxt;
  logic [COUNT_W-1:0]   peak_r, peak_nxt;
  logic [TOP_W-1:0]     init_idx_r, init_idx_nxt;
  logic [ADDR_BITS-1:0] init_acc_r, init_acc_nxt;
  logic                 grant_ok_r, grant_ok_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic [31:0]          out_granted_r, out_granted_nxt;
  status_t              out_status_r, out_status_nxt;
  logic [COUNT_W-1:0]   out_used_r, out_used_nxt;
  logic [COUNT_W-1:0]   out_peak_r, out_peak_nxt;
  logic                 out_all_free_r, out_all_free_nxt;

  logic                 in_fire;
  opcode_t              op;
  logic [CMP_W-1:0]     slots_eff;
  logic [ADDR_BITS-1:0] addr_in;
  logic [ADDR_BITS-1:0] base_a;
  logic [ADDR_BITS-1:0] offset;
  logic [SPAN_W-1:0]    span;
  logic                 in_region;
  logic                 init_busy;
  logic                 init_done;

  logic                 wr_en;
  logic [MEM_AW-1:0]    wr_addr;
  logic [ADDR_BITS-1:0] wr_data;
  logic                 rd_en;
  logic [MEM_AW-1:0]    rd_addr;
  logic [ADDR_BITS-1:0] rd_data;
  logic [TOP_W-1:0]     top_dec;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r  <= RST_BASE;
      esize_r <= RST_ESIZE;
      slots_r <= RST_SLOTS;
    end else if (cfg_valid) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_BASE:  base_r  <= cfg_data;
        CFG_ESIZE: esize_r <= cfg_data[ESIZE_W-1:0];
        CFG_SLOTS: slots_r <= cfg_data[SLOT_W-1:0];
        CFG_NONE:  ;
      endcase
    end
  end

  assign in_ready  = (state_r == ST_IDLE) && (!out_valid_r || out_ready);
  assign in_fire   = in_valid && in_ready;
  assign op        = opcode_t'(in_opcode);

  assign slots_eff = (CMP_W'(slots_r) > CMP_W'(MAX_SLOTS)) ? CMP_W'(MAX_SLOTS)
                                                             : CMP_W'(slots_r);
  assign addr_in   = ADDR_BITS'(in_block_address);
  assign base_a    = ADDR_BITS'(base_r);
  assign offset    = addr_in - base_a;
  assign span      = SPAN_W'(esize_r) * SPAN_W'(slots_eff[SLOT_W-1:0]);
  assign in_region = RW'(offset) < RW'(span);
  assign top_dec   = stack_top_r - TOP_W'(1);

  assign init_busy = (state_r == ST_INIT) && (CMP_W'(init_idx_r) < slots_eff);
  assign init_done = (state_r == ST_INIT) && !init_busy;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire && op == OP_INIT) begin
          state_nxt = ST_INIT;
        end else if (in_fire && op == OP_ALLOC) begin
          state_nxt = ST_ALLOC;
        end
      end
      ST_INIT: begin
        if (init_done) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_ALLOC: state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    stack_top_nxt    = stack_top_r;
    used_nxt         = used_r;
    peak_nxt         = peak_r;
    init_idx_nxt     = init_idx_r;
    init_acc_nxt     = init_acc_r;
    grant_ok_nxt     = grant_ok_r;
    out_valid_nxt    = out_valid_r && !out_ready;
    out_granted_nxt  = out_granted_r;
    out_status_nxt   = out_status_r;
    out_used_nxt     = out_used_r;
    out_peak_nxt     = out_peak_r;
    out_all_free_nxt = out_all_free_r;
    wr_en            = 1'b0;
    wr_addr          = stack_top_r[MEM_AW-1:0];
    wr_data          = addr_in;
    rd_en            = 1'b0;
    rd_addr          = top_dec[MEM_AW-1:0];

    if (in_fire) begin
      out_granted_nxt = '0;
      out_status_nxt  = STS_OK;
      unique case (op)
        OP_INIT: begin
          init_idx_nxt  = '0;
          init_acc_nxt  = base_a;
          out_valid_nxt = 1'b0;
        end
        OP_ALLOC: begin
          out_valid_nxt = 1'b0;
          if (stack_top_r == '0) begin
            grant_ok_nxt   = 1'b0;
            out_status_nxt = STS_EMPTY;
          end else begin
            grant_ok_nxt  = 1'b1;
            rd_en         = 1'b1;
            stack_top_nxt = top_dec;
            if (used_r != COUNT_MAX) begin
              used_nxt = used_r + COUNT_W'(1);
            end
            if (used_nxt > peak_r) begin
              peak_nxt = used_nxt;
            end
          end
        end
        OP_FREE: begin
          out_valid_nxt = 1'b1;
          if (addr_in == '0) begin
            out_status_nxt = STS_NULL;
          end else if (!in_region) begin
            out_status_nxt = STS_RANGE;
          end else if (CMP_W'(stack_top_r) >= slots_eff) begin
            out_status_nxt = STS_FULL;
          end else begin
            wr_en         = 1'b1;
            stack_top_nxt = stack_top_r + TOP_W'(1);
            if (used_r != '0) begin
              used_nxt = used_r - COUNT_W'(1);
            end
          end
        end
        OP_NOP: begin
          out_valid_nxt = 1'b1;
        end
      endcase
      out_used_nxt     = used_nxt;
      out_peak_nxt     = peak_nxt;
      out_all_free_nxt = (CMP_W'(stack_top_nxt) == slots_eff);
    end

    if (init_busy) begin
      wr_en        = 1'b1;
      wr_addr      = init_idx_r[MEM_AW-1:0];
      wr_data      = init_acc_r;
      init_idx_nxt = init_idx_r + TOP_W'(1);
      init_acc_nxt = init_acc_r + ADDR_BITS'(esize_r);
    end

    if (init_done) begin
      stack_top_nxt    = TOP_W'(slots_eff);
      used_nxt         = '0;
      peak_nxt         = '0;
      out_valid_nxt    = 1'b1;
      out_granted_nxt  = '0;
      out_status_nxt   = STS_OK;
      out_used_nxt     = '0;
      out_peak_nxt     = '0;
      out_all_free_nxt = 1'b1;
    end

    if (state_r == ST_ALLOC) begin
      out_valid_nxt   = 1'b1;
      out_granted_nxt = grant_ok_r ? 32'(rd_data) : 32'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      stack_top_r <= '0;
      used_r      <= '0;
      peak_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      stack_top_r <= stack_top_nxt;
      used_r      <= used_nxt;
      peak_r      <= peak_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    init_idx_r     <= init_idx_nxt;
    init_acc_r     <= init_acc_nxt;
    grant_ok_r     <= grant_ok_nxt;
    out_granted_r  <= out_granted_nxt;
    out_status_r   <= out_status_nxt;
    out_used_r     <= out_used_nxt;
    out_peak_r     <= out_peak_nxt;
    out_all_free_r <= out_all_free_nxt;
  end

  fbfla_stack_mem #(
    .DEPTH (MAX_SLOTS),
    .WIDTH (ADDR_BITS)
  ) u_stack_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign out_valid           = out_valid_r;
  assign out_granted_address = out_granted_r;
  assign out_status          = out_status_r;
  assign out_in_use_count    = out_used_r;
  assign out_high_water      = out_peak_r;
  assign out_all_free        = out_all_free_r;

  `FBFLA_NEVER(a_top_bound, CMP_W'(stack_top_r) > CMP_W'(MAX_SLOTS))
  `FBFLA_NEVER(a_rd_wr_excl, wr_en && rd_en)
  `FBFLA_NEVER(a_busy_no_accept, in_ready && state_r != ST_IDLE)
  `FBFLA_ASSERT(a_alloc_read, (in_fire && op == OP_ALLOC) |=> (state_r == ST_ALLOC))
  `FBFLA_ASSERT(a_alloc_result, (state_r == ST_ALLOC) |=> out_valid_r)

endmodule
